// File: rtl/core/sctq_pkg.sv
// Shared types and constants of the sorted countdown timer queue.
package sctq_pkg;

    localparam int DELAY_BITS    = 8;
    localparam int KEY_PORT_BITS = 16;
    localparam int POS_BITS      = 5;

    typedef enum logic [2:0] {
        OP_ADD        = 3'd0,
        OP_CANCEL_KEY = 3'd1,
        OP_CANCEL_POS = 3'd2,
        OP_CLEAR      = 3'd3,
        OP_QUERY      = 3'd4,
        OP_TICK       = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

endpackage

// File: rtl/core/sctq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sctq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/sorted_countdown_timer_queue.sv
// Sorted countdown timer queue: alarm table walked one entry a cycle by a small sequencer,
// unless a tick expiry waits on a stalled output. An add, cancel, query or tick reads every
// entry held through the one RAM read port before its final transaction; clear, unused codes
// and an add to a full table skip that walk. A stalled output holds the final transaction.
// One transaction is in work at a time; the next is accepted once the final result is queued.
// Reset (synchronous, active low) empties the table; entry contents are not cleared.
module sorted_countdown_timer_queue #(
    parameter int TABLE_DEPTH = 32,
    parameter int KEY_BITS    = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [2:0]                          i_operation,
    input  logic [sctq_pkg::DELAY_BITS-1:0]     i_delay_days,
    input  logic [sctq_pkg::KEY_PORT_BITS-1:0]  i_alarm_key,
    input  logic                                i_start_active,
    input  logic [sctq_pkg::POS_BITS-1:0]       i_position,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [1:0]                          o_status,
    output logic                                o_expired_valid,
    output logic [sctq_pkg::KEY_PORT_BITS-1:0]  o_expired_key,
    output logic [sctq_pkg::DELAY_BITS-1:0]     o_days_left,
    output logic                                o_last
);

    import sctq_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = DELAY_BITS + KEY_BITS + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    t_state r_state, n_state;
    logic [2:0]            r_op, n_op;
    logic [DELAY_BITS-1:0] r_delay, n_delay;
    logic [KEY_BITS-1:0]   r_key, n_key;
    logic                  r_act, n_act;
    logic [POS_BITS-1:0]   r_pos, n_pos;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_rp, n_rp;
    logic                  r_dv, n_dv;
    logic [AW-1:0]         r_ri, n_ri;
    logic                  r_flag, n_flag;
    logic [EW-1:0]         r_carry, n_carry;
    logic [CW-1:0]         r_drop, n_drop;
    logic                  r_pend, n_pend;
    logic [KEY_BITS-1:0]   r_pend_key, n_pend_key;
    logic [DELAY_BITS-1:0] r_days, n_days;

    logic                  r_ovalid, n_ovalid;
    t_status               r_status, n_status;
    logic                  r_exp_valid, n_exp_valid;
    logic [KEY_BITS-1:0]   r_exp_key, n_exp_key;
    logic [DELAY_BITS-1:0] r_days_out, n_days_out;
    logic                  r_last, n_last;

    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [EW-1:0]         ram_wdata, ram_rdata;

    logic [DELAY_BITS-1:0] e_delay, t_delay;
    logic [KEY_BITS-1:0]   e_key, in_key;
    logic                  e_act;
    logic [EW-1:0]         e_tick, new_entry;
    logic                  out_free, need_emit, emit, match;
    logic [KEY_BITS+KEY_PORT_BITS-1:0] key_in_ext, key_out_ext;
    logic [AW+POS_BITS-1:0] pos_ext, ri_ext;

    sctq_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Resize keys between the port width and the stored width.
    assign key_in_ext = {{KEY_BITS{1'b0}}, i_alarm_key};
    assign in_key     = key_in_ext[KEY_BITS-1:0];
    assign key_out_ext = {{KEY_PORT_BITS{1'b0}}, r_exp_key};

    assign e_delay = ram_rdata[EW-1 -: DELAY_BITS];
    assign e_key   = ram_rdata[KEY_BITS:1];
    assign e_act   = ram_rdata[0];

    // Tick: decrement active entries, saturating at zero; activate inactive ones.
    assign t_delay   = (e_act && e_delay != '0) ? e_delay - DELAY_BITS'(1) : e_delay;
    assign e_tick    = {t_delay, e_key, 1'b1};
    assign new_entry = {r_delay, r_key, r_act};

    assign pos_ext = {{AW{1'b0}}, r_pos};
    assign ri_ext  = {{POS_BITS{1'b0}}, r_ri};
    assign match   = (t_op'(r_op) == OP_CANCEL_KEY) ? (e_key == r_key) : (pos_ext == ri_ext);

    assign out_free = !r_ovalid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_delay     <= n_delay;
        r_key       <= n_key;
        r_act       <= n_act;
        r_pos       <= n_pos;
        r_rp        <= n_rp;
        r_dv        <= n_dv;
        r_ri        <= n_ri;
        r_flag      <= n_flag;
        r_carry     <= n_carry;
        r_drop      <= n_drop;
        r_pend      <= n_pend;
        r_pend_key  <= n_pend_key;
        r_days      <= n_days;
        r_status    <= n_status;
        r_exp_valid <= n_exp_valid;
        r_exp_key   <= n_exp_key;
        r_days_out  <= n_days_out;
        r_last      <= n_last;
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_delay     = r_delay;
        n_key       = r_key;
        n_act       = r_act;
        n_pos       = r_pos;
        n_count     = r_count;
        n_rp        = r_rp;
        n_dv        = r_dv;
        n_ri        = r_ri;
        n_flag      = r_flag;
        n_carry     = r_carry;
        n_drop      = r_drop;
        n_pend      = r_pend;
        n_pend_key  = r_pend_key;
        n_days      = r_days;
        n_status    = r_status;
        n_exp_valid = r_exp_valid;
        n_exp_key   = r_exp_key;
        n_days_out  = r_days_out;
        n_last      = r_last;
        ram_we      = 1'b0;
        ram_waddr   = r_ri;
        ram_wdata   = r_carry;
        ram_re      = 1'b0;
        ram_raddr   = r_rp[AW-1:0];
        need_emit   = 1'b0;
        emit        = 1'b0;

        // Payload of the transaction to queue, plain result by default.
        n_status    = r_status;
        if (r_ovalid && !i_stall) begin
            n_status = ST_OK;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op       = i_operation;
                    n_delay    = i_delay_days;
                    n_key      = in_key;
                    n_act      = i_start_active;
                    n_pos      = i_position;
                    n_rp       = '0;
                    n_dv       = 1'b0;
                    n_flag     = 1'b0;
                    n_drop     = '0;
                    n_pend     = 1'b0;
                    n_days     = '0;
                    case (t_op'(i_operation))
                        OP_ADD:                    n_state = (r_count >= DEPTH_C) ? S_FINISH
                                                                                  : S_SCAN;
                        OP_CANCEL_KEY, OP_CANCEL_POS,
                        OP_QUERY, OP_TICK:         n_state = S_SCAN;
                        default:                   n_state = S_FINISH;
                    endcase
                end
            end

            S_SCAN: begin
                // Hold the current entry while a tick expiry cannot be queued.
                if (r_dv && t_op'(r_op) == OP_TICK && r_pend) begin
                    need_emit = 1'b1;
                end
                if (!need_emit || out_free) begin
                    if (r_dv) begin
                        case (t_op'(r_op))
                            OP_ADD: begin
                                if (r_flag) begin
                                    ram_we    = 1'b1;
                                    ram_waddr = r_ri;
                                    ram_wdata = r_carry;
                                    n_carry   = ram_rdata;
                                end else if (e_delay > r_delay) begin
                                    ram_we    = 1'b1;
                                    ram_waddr = r_ri;
                                    ram_wdata = new_entry;
                                    n_carry   = ram_rdata;
                                    n_flag    = 1'b1;
                                end
                            end
                            OP_CANCEL_KEY, OP_CANCEL_POS: begin
                                if (r_flag) begin
                                    ram_we    = 1'b1;
                                    ram_waddr = r_ri - AW'(1);
                                    ram_wdata = ram_rdata;
                                end else if (match) begin
                                    n_flag = 1'b1;
                                end
                            end
                            OP_QUERY: begin
                                if (!r_flag && e_key == r_key) begin
                                    n_flag = 1'b1;
                                    n_days = e_delay;
                                end
                            end
                            OP_TICK: begin
                                if (!r_flag && t_delay == '0) begin
                                    // Expired: drop it and queue the previous expiry.
                                    n_drop     = r_drop + CW'(1);
                                    n_pend     = 1'b1;
                                    n_pend_key = e_key;
                                    if (r_pend) begin
                                        emit        = 1'b1;
                                        n_exp_valid = 1'b1;
                                        n_exp_key   = r_pend_key;
                                        n_last      = 1'b0;
                                    end
                                end else begin
                                    ram_we    = 1'b1;
                                    ram_waddr = r_ri - r_drop[AW-1:0];
                                    ram_wdata = e_tick;
                                    n_flag    = 1'b1;
                                    if (r_pend) begin
                                        n_pend      = 1'b0;
                                        emit        = 1'b1;
                                        n_exp_valid = 1'b1;
                                        n_exp_key   = r_pend_key;
                                        n_last      = 1'b1;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    if (r_rp < r_count) begin
                        ram_re = 1'b1;
                        n_ri   = r_rp[AW-1:0];
                        n_dv   = 1'b1;
                        n_rp   = r_rp + CW'(1);
                    end else begin
                        n_dv    = 1'b0;
                        n_state = S_FINISH;
                    end
                end
            end

            S_FINISH: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    emit        = 1'b1;
                    n_exp_valid = 1'b0;
                    n_exp_key   = '0;
                    n_days_out  = '0;
                    n_last      = 1'b1;
                    n_status    = ST_OK;
                    case (t_op'(r_op))
                        OP_ADD: begin
                            if (r_count >= DEPTH_C) begin
                                n_status = ST_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_count[AW-1:0];
                                ram_wdata = r_flag ? r_carry : new_entry;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        OP_CANCEL_KEY, OP_CANCEL_POS: begin
                            if (r_flag) begin
                                n_count = r_count - CW'(1);
                            end else begin
                                n_status = ST_NOT_FOUND;
                            end
                        end
                        OP_CLEAR: begin
                            n_count = '0;
                        end
                        OP_QUERY: begin
                            if (r_flag) begin
                                n_days_out = r_days;
                            end else begin
                                n_status = ST_NOT_FOUND;
                            end
                        end
                        OP_TICK: begin
                            n_count = r_count - r_drop;
                            if (r_pend) begin
                                n_exp_valid = 1'b1;
                                n_exp_key   = r_pend_key;
                            end else if (r_drop != '0) begin
                                // Final expiry already went out during the walk.
                                emit = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Expiries queued during the walk carry status ok and no days.
        if (emit && r_state == S_SCAN) begin
            n_status   = ST_OK;
            n_days_out = '0;
        end

        n_ovalid = r_ovalid && i_stall;
        if (emit) begin
            n_ovalid = 1'b1;
        end
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_ovalid;
    assign o_status        = r_status;
    assign o_expired_valid = r_exp_valid;
    assign o_expired_key   = key_out_ext[KEY_PORT_BITS-1:0];
    assign o_days_left     = r_days_out;
    assign o_last          = r_last;

endmodule

// File: tb/sv/sorted_countdown_timer_queue_test.sv
// Testbench for the sorted countdown timer queue: directed table, then random traffic.
module sorted_countdown_timer_queue_test;
    import sctq_pkg::*;

    localparam int DEPTH          = 32;
    localparam int RANDOM_ITEMS   = 405;
    localparam int IDLE_PCT       = 19;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 80;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    typedef struct {
        logic [2:0]  op;
        logic [7:0]  delay;
        logic [15:0] key;
        logic        act;
        logic [4:0]  pos;
    } t_timer_cmd;

    typedef struct {
        logic [1:0]  status;
        logic        xv;
        logic [15:0] xkey;
        logic [7:0]  days;
        logic        last;
    } t_timer_resp;

    typedef struct {
        t_timer_cmd  cmd;
        bit          typed;
        t_timer_resp resp;
    } t_directed_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_operation;
    logic [7:0]  i_delay_days;
    logic [15:0] i_alarm_key;
    logic        i_start_active;
    logic [4:0]  i_position;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_status;
    logic        o_expired_valid;
    logic [15:0] o_expired_key;
    logic [7:0]  o_days_left;
    logic        o_last;

    // Shadow copy of the alarm table
    logic [7:0]  alarm_delay [DEPTH];
    logic [15:0] alarm_ident [DEPTH];
    logic        alarm_live  [DEPTH];
    int          alarm_count;

    t_timer_resp   due_results [$];
    t_timer_resp   head_result;
    t_directed_row directed_rows [$];

    bit steady_run;
    int fail_count;
    int results_seen;
    int full_seen;
    int longest_run;
    int idle_cycles;
    int op_seen [8];

    sorted_countdown_timer_queue #(
        .TABLE_DEPTH(DEPTH),
        .KEY_BITS   (16)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_delay_days   (i_delay_days),
        .i_alarm_key    (i_alarm_key),
        .i_start_active (i_start_active),
        .i_position     (i_position),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_expired_valid(o_expired_valid),
        .o_expired_key  (o_expired_key),
        .o_days_left    (o_days_left),
        .o_last         (o_last)
    );

    always #1 i_clk = ~i_clk;

    // Apply one transaction to the shadow table and queue the results it causes.
    task automatic run_timer_op(input t_timer_cmd c);
        int          i;
        int          hit;
        int          n;
        t_timer_resp r;
        r.status = ST_OK;
        r.xv     = 1'b0;
        r.xkey   = '0;
        r.days   = '0;
        r.last   = 1'b1;
        hit      = 0;
        case (c.op)
            OP_ADD: begin
                if (alarm_count >= DEPTH) begin
                    r.status = ST_FULL;
                    full_seen++;
                end else begin
                    // insert after every entry whose delay is not greater
                    while (hit < alarm_count && alarm_delay[hit] <= c.delay) hit++;
                    for (i = alarm_count; i > hit; i--) begin
                        alarm_delay[i] = alarm_delay[i-1];
                        alarm_ident[i] = alarm_ident[i-1];
                        alarm_live[i]  = alarm_live[i-1];
                    end
                    alarm_delay[hit] = c.delay;
                    alarm_ident[hit] = c.key;
                    alarm_live[hit]  = c.act;
                    alarm_count++;
                end
            end
            OP_CANCEL_KEY, OP_CANCEL_POS, OP_QUERY: begin
                if (c.op == OP_CANCEL_POS) begin
                    hit = (c.pos < alarm_count) ? int'(c.pos) : -1;
                end else begin
                    while (hit < alarm_count && alarm_ident[hit] != c.key) hit++;
                    if (hit == alarm_count) hit = -1;
                end
                if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                end else if (c.op == OP_QUERY) begin
                    r.days = alarm_delay[hit];
                end else begin
                    for (i = hit; i + 1 < alarm_count; i++) begin
                        alarm_delay[i] = alarm_delay[i+1];
                        alarm_ident[i] = alarm_ident[i+1];
                        alarm_live[i]  = alarm_live[i+1];
                    end
                    alarm_count--;
                end
            end
            OP_CLEAR: alarm_count = 0;
            OP_TICK: begin
                // count down active entries, saturating; wake inactive ones
                for (i = 0; i < alarm_count; i++) begin
                    if (alarm_live[i]) begin
                        if (alarm_delay[i] != 8'd0) alarm_delay[i] = alarm_delay[i] - 8'd1;
                    end else begin
                        alarm_live[i] = 1'b1;
                    end
                end
                n = 0;
                while (n < alarm_count && alarm_delay[n] == 8'd0) n++;
                if (n > longest_run) longest_run = n;
                for (i = 0; i < n; i++) begin
                    r.xv   = 1'b1;
                    r.xkey = alarm_ident[i];
                    r.last = (i == n - 1);
                    due_results = {due_results, r};
                end
                for (i = n; i < alarm_count; i++) begin
                    alarm_delay[i-n] = alarm_delay[i];
                    alarm_ident[i-n] = alarm_ident[i];
                    alarm_live[i-n]  = alarm_live[i];
                end
                alarm_count -= n;
            end
            default: ;
        endcase
        if (c.op != OP_TICK || r.xv == 1'b0) due_results = {due_results, r};
    endtask

    // Hold the transaction on the input until it is accepted.
    task automatic send_cmd(input t_timer_cmd c);
        while (!steady_run && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_operation    <= c.op;
        i_delay_days   <= c.delay;
        i_alarm_key    <= c.key;
        i_start_active <= c.act;
        i_position     <= c.pos;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        run_timer_op(c);
        op_seen[c.op]++;
    endtask

    // Append one row to the directed table.
    task automatic add_row(input logic [2:0] op, input logic [7:0] delay,
                           input logic [15:0] key, input logic act,
                           input logic [4:0] pos, input bit typed,
                           input logic [1:0] status, input logic [7:0] days);
        t_directed_row d;
        d.cmd.op      = op;
        d.cmd.delay   = delay;
        d.cmd.key     = key;
        d.cmd.act     = act;
        d.cmd.pos     = pos;
        d.typed       = typed;
        d.resp.status = status;
        d.resp.xv     = 1'b0;
        d.resp.xkey   = '0;
        d.resp.days   = days;
        d.resp.last   = 1'b1;
        directed_rows = {directed_rows, d};
    endtask

    // Phase 0 fills the table, phase 1 mixes everything, phase 2 drains by ticking.
    function automatic t_timer_cmd random_cmd(input int phase);
        t_timer_cmd c;
        int         roll;
        int         add_cut;
        int         tick_cut;
        int         query_cut;
        int         ckey_cut;
        int         cpos_cut;
        int         clear_cut;
        case (phase)
            0: begin
                add_cut = 75; tick_cut = 85; query_cut = 92;
                ckey_cut = 96; cpos_cut = 100; clear_cut = 100;
            end
            1: begin
                add_cut = 35; tick_cut = 60; query_cut = 72;
                ckey_cut = 82; cpos_cut = 92; clear_cut = 95;
            end
            default: begin
                add_cut = 15; tick_cut = 70; query_cut = 80;
                ckey_cut = 90; cpos_cut = 100; clear_cut = 100;
            end
        endcase
        roll = $urandom_range(99);
        if (roll < add_cut)        c.op = OP_ADD;
        else if (roll < tick_cut)  c.op = OP_TICK;
        else if (roll < query_cut) c.op = OP_QUERY;
        else if (roll < ckey_cut)  c.op = OP_CANCEL_KEY;
        else if (roll < cpos_cut)  c.op = OP_CANCEL_POS;
        else if (roll < clear_cut) c.op = OP_CLEAR;
        else                       c.op = $urandom_range(1) ? OP_SPARE_7 : OP_SPARE_6;

        c.delay = ($urandom_range(99) < 70) ? 8'($urandom_range(6)) : 8'($urandom_range(255));
        c.key   = ($urandom_range(1) != 0) ? 16'($urandom_range(15))
                                          : 16'($urandom_range(65535));
        c.act   = 1'($urandom_range(1));
        c.pos   = 5'($urandom_range(31));
        // aim lookups and cancels at live entries most of the time
        if (alarm_count > 0 && $urandom_range(99) < 60) begin
            if (c.op == OP_QUERY || c.op == OP_CANCEL_KEY)
                c.key = alarm_ident[$urandom_range(alarm_count - 1)];
            else if (c.op == OP_CANCEL_POS)
                c.pos = 5'($urandom_range(alarm_count - 1));
        end
        return c;
    endfunction

    // Result checker; also drives the output-side stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (due_results.size() == 0) begin
                fail_count++;
                $error("unexpected result: status %0d expired %0d key %h days %0d last %0d",
                       o_status, o_expired_valid, o_expired_key, o_days_left, o_last);
            end else begin
                head_result = due_results.pop_front();
                if (o_status !== head_result.status) begin
                    fail_count++;
                    $error("status: expected %0d, got %0d", head_result.status, o_status);
                end
                if (o_expired_valid !== head_result.xv) begin
                    fail_count++;
                    $error("expired_valid: expected %0d, got %0d",
                           head_result.xv, o_expired_valid);
                end
                if (o_expired_key !== head_result.xkey) begin
                    fail_count++;
                    $error("expired_key: expected %h, got %h", head_result.xkey, o_expired_key);
                end
                if (o_days_left !== head_result.days) begin
                    fail_count++;
                    $error("days_left: expected %0d, got %0d", head_result.days, o_days_left);
                end
                if (o_last !== head_result.last) begin
                    fail_count++;
                    $error("last: expected %0d, got %0d", head_result.last, o_last);
                end
            end
        end
        i_stall <= (!i_rst_n || steady_run) ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
    end

    // Watchdog: end the run if neither side moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_stall        <= 1'b0;
        i_operation    <= OP_CLEAR;
        i_delay_days   <= '0;
        i_alarm_key    <= '0;
        i_start_active <= 1'b0;
        i_position     <= '0;
        idle_cycles    <= 0;
        steady_run  = 1'b0;
        fail_count  = 0;
        results_seen = 0;
        full_seen   = 0;
        longest_run = 0;
        alarm_count = 0;
        foreach (op_seen[k]) op_seen[k] = 0;

        //      op             delay   key       act   pos    typed status        days
        add_row(OP_TICK,       8'd0,   16'h0000, 1'b0, 5'd0,  1, ST_OK,        8'd0);
        add_row(OP_QUERY,      8'd0,   16'h0000, 1'b0, 5'd0,  1, ST_NOT_FOUND, 8'd0);
        add_row(OP_CANCEL_KEY, 8'd0,   16'hFFFF, 1'b0, 5'd0,  1, ST_NOT_FOUND, 8'd0);
        add_row(OP_CANCEL_POS, 8'd0,   16'h0000, 1'b0, 5'd31, 1, ST_NOT_FOUND, 8'd0);
        add_row(OP_ADD,        8'd255, 16'hFFFF, 1'b1, 5'd0,  1, ST_OK,        8'd0);
        add_row(OP_ADD,        8'd0,   16'h0000, 1'b0, 5'd0,  1, ST_OK,        8'd0);
        add_row(OP_ADD,        8'd3,   16'h1234, 1'b0, 5'd0,  0, ST_OK,        8'd0);
        add_row(OP_ADD,        8'd3,   16'h5678, 1'b1, 5'd0,  0, ST_OK,        8'd0);
        add_row(OP_QUERY,      8'd0,   16'hFFFF, 1'b0, 5'd0,  1, ST_OK,        8'd255);
        add_row(OP_TICK,       8'd0,   16'h0000, 1'b0, 5'd0,  0, ST_OK,        8'd0);
        add_row(OP_QUERY,      8'd0,   16'h1234, 1'b0, 5'd0,  0, ST_OK,        8'd0);
        add_row(OP_QUERY,      8'd0,   16'h5678, 1'b0, 5'd0,  0, ST_OK,        8'd0);
        add_row(OP_CANCEL_POS, 8'd0,   16'h0000, 1'b0, 5'd5,  1, ST_NOT_FOUND, 8'd0);
        add_row(OP_CANCEL_POS, 8'd0,   16'h0000, 1'b0, 5'd0,  0, ST_OK,        8'd0);
        add_row(OP_CANCEL_KEY, 8'd0,   16'hFFFF, 1'b0, 5'd0,  0, ST_OK,        8'd0);
        add_row(OP_SPARE_6,    8'd0,   16'h0000, 1'b0, 5'd0,  1, ST_OK,        8'd0);
        add_row(OP_SPARE_7,    8'd255, 16'hFFFF, 1'b1, 5'd31, 1, ST_OK,        8'd0);
        add_row(OP_CLEAR,      8'd0,   16'h0000, 1'b0, 5'd0,  1, ST_OK,        8'd0);
        add_row(OP_QUERY,      8'd0,   16'h1234, 1'b0, 5'd0,  1, ST_NOT_FOUND, 8'd0);
        // an inactive entry ahead of an active one of equal delay: the later one
        // reaches zero first, stays there, and both leave together
        add_row(OP_ADD,        8'd1,   16'h00A5, 1'b0, 5'd0,  0, ST_OK,        8'd0);
        add_row(OP_ADD,        8'd1,   16'h5A00, 1'b1, 5'd0,  0, ST_OK,        8'd0);
        add_row(OP_TICK,       8'd0,   16'h0000, 1'b0, 5'd0,  0, ST_OK,        8'd0);
        add_row(OP_QUERY,      8'd0,   16'h5A00, 1'b0, 5'd0,  0, ST_OK,        8'd0);
        add_row(OP_TICK,       8'd0,   16'h0000, 1'b0, 5'd0,  0, ST_OK,        8'd0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[j]) begin
            send_cmd(directed_rows[j].cmd);
            if (directed_rows[j].typed)
                due_results[due_results.size() - 1] = directed_rows[j].resp;
        end

        for (int j = 0; j < RANDOM_ITEMS; j++) begin
            steady_run = (j >= 160 && j < 260);
            send_cmd(random_cmd((j / 45) % 3));
        end
        steady_run = 1'b0;
        i_valid <= 1'b0;

        while (due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d adds, %0d key cancels, %0d position cancels, %0d clears, %0d queries,",
                 op_seen[OP_ADD], op_seen[OP_CANCEL_KEY], op_seen[OP_CANCEL_POS],
                 op_seen[OP_CLEAR], op_seen[OP_QUERY]);
        $display("%0d ticks, %0d spare codes; %0d results, %0d full-table adds,",
                 op_seen[OP_TICK], op_seen[OP_SPARE_6] + op_seen[OP_SPARE_7], results_seen,
                 full_seen);
        $display("longest expiry run %0d", longest_run);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
